// ----- design/bacl_pkg.sv -----
// ----------------------------------------------------------------------------
// bacl_pkg
// Shared types and key codes for the BCD alarm clock keypad control block.
// ----------------------------------------------------------------------------
package bacl_pkg;

    localparam int KEY_W   = 5;
    localparam int DIGIT_W = 4;
    localparam int NDIGITS = 6;

    localparam logic [KEY_W-1:0] KEY_RUN       = 5'd10;
    localparam logic [KEY_W-1:0] KEY_STOP      = 5'd11;
    localparam logic [KEY_W-1:0] KEY_SET_TIME  = 5'd12;
    localparam logic [KEY_W-1:0] KEY_CLEAR     = 5'd13;
    localparam logic [KEY_W-1:0] KEY_SET_ALARM = 5'd14;
    localparam logic [KEY_W-1:0] KEY_TICK      = 5'd16;

    localparam logic [7:0] HOURS_PER_DAY = 8'd24;
    localparam logic [3:0] LAST_ONES     = 4'd9;
    localparam logic [3:0] LAST_TENS     = 4'd5;

    typedef enum logic [1:0] {
        MODE_RUN       = 2'd0,
        MODE_STOPPED   = 2'd1,
        MODE_SET_TIME  = 2'd2,
        MODE_SET_ALARM = 2'd3
    } t_mode;

    // index 0: hour tens ... index 5: second ones
    typedef logic [NDIGITS-1:0][DIGIT_W-1:0] t_digits;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [3:0] minute_tens;
        logic [3:0] minute_ones;
        logic [3:0] second_tens;
        logic [3:0] second_ones;
        t_mode      mode;
        logic       alarm_beep;
        logic       error_beep;
    } t_result;

endpackage

// ----- design/bacl_if.sv -----
// ----------------------------------------------------------------------------
// bacl_key_if / bacl_res_if
// Valid/ready channels carrying key requests and display results.
// ----------------------------------------------------------------------------
interface bacl_key_if;
    logic       valid;
    logic       ready;
    logic [4:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

interface bacl_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [3:0] minute_tens;
    logic [3:0] minute_ones;
    logic [3:0] second_tens;
    logic [3:0] second_ones;
    logic [1:0] mode;
    logic       alarm_beep;
    logic       error_beep;

    modport source (
        output valid, output hour_tens, output hour_ones, output minute_tens,
        output minute_ones, output second_tens, output second_ones,
        output mode, output alarm_beep, output error_beep, input ready
    );
    modport sink (
        input valid, input hour_tens, input hour_ones, input minute_tens,
        input minute_ones, input second_tens, input second_ones,
        input mode, input alarm_beep, input error_beep, output ready
    );
endinterface

// ----- design/bacl_tick.sv -----
// ----------------------------------------------------------------------------
// bacl_tick
// One-second advance of HH:MM:SS BCD digits with 24-hour wrap.
// ----------------------------------------------------------------------------
module bacl_tick (
    input  bacl_pkg::t_digits i_digits,
    output bacl_pkg::t_digits o_digits
);

    always_comb begin
        o_digits = i_digits;
        if (i_digits[5] != bacl_pkg::LAST_ONES) begin
            o_digits[5] = i_digits[5] + 4'd1;
        end else if (i_digits[4] != bacl_pkg::LAST_TENS) begin
            o_digits[5] = '0;
            o_digits[4] = i_digits[4] + 4'd1;
        end else if (i_digits[3] != bacl_pkg::LAST_ONES) begin
            o_digits[5] = '0;
            o_digits[4] = '0;
            o_digits[3] = i_digits[3] + 4'd1;
        end else if (i_digits[2] != bacl_pkg::LAST_TENS) begin
            o_digits[5] = '0;
            o_digits[4] = '0;
            o_digits[3] = '0;
            o_digits[2] = i_digits[2] + 4'd1;
        end else begin
            o_digits[5] = '0;
            o_digits[4] = '0;
            o_digits[3] = '0;
            o_digits[2] = '0;
            if (i_digits[1] == bacl_pkg::LAST_ONES && i_digits[0] <= 4'd1) begin
                o_digits[1] = '0;
                o_digits[0] = i_digits[0] + 4'd1;
            end else if (i_digits[1] == 4'd3 && i_digits[0] == 4'd2) begin
                o_digits[1] = '0;
                o_digits[0] = '0;
            end else begin
                o_digits[1] = i_digits[1] + 4'd1;
            end
        end
    end

endmodule

// ----- design/bacl_core.sv -----
// ----------------------------------------------------------------------------
// bacl_core
// Mode state machine, time and alarm digit registers, per-key update.
// ----------------------------------------------------------------------------
module bacl_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [4:0]        i_key,
    output bacl_pkg::t_result o_res
);

    bacl_pkg::t_mode   r_mode;
    bacl_pkg::t_mode   n_mode;
    bacl_pkg::t_digits r_time;
    bacl_pkg::t_digits n_time;
    bacl_pkg::t_digits r_alarm;
    bacl_pkg::t_digits n_alarm;
    bacl_pkg::t_digits w_ticked;
    bacl_pkg::t_digits w_edit;
    bacl_pkg::t_digits w_shifted;
    logic              w_edit_ok;
    logic              w_leave;
    logic              w_digit;
    logic              w_alarm;
    logic              w_err;

    function automatic logic digits_valid(input bacl_pkg::t_digits d);
        logic [7:0] hours;
        hours = {1'b0, d[0], 3'b000} + {3'b000, d[0], 1'b0} + {4'b0000, d[1]};
        return (d[4] <= bacl_pkg::LAST_TENS) && (d[2] <= bacl_pkg::LAST_TENS) &&
               (hours < bacl_pkg::HOURS_PER_DAY);
    endfunction

    bacl_tick u_tick (
        .i_digits (r_time),
        .o_digits (w_ticked)
    );

    assign w_edit    = (r_mode == bacl_pkg::MODE_SET_ALARM) ? r_alarm : r_time;
    assign w_edit_ok = digits_valid(w_edit);
    assign w_leave   = (i_key == bacl_pkg::KEY_RUN) || (i_key == bacl_pkg::KEY_STOP);
    assign w_digit   = i_key < 5'd10;
    assign w_shifted = {i_key[3:0], w_edit[5:1]};

    // next state
    always_comb begin
        n_mode = r_mode;
        unique case (r_mode)
            bacl_pkg::MODE_RUN: begin
                if (i_key == bacl_pkg::KEY_STOP) n_mode = bacl_pkg::MODE_STOPPED;
            end
            bacl_pkg::MODE_STOPPED: begin
                priority if (i_key == bacl_pkg::KEY_RUN) n_mode = bacl_pkg::MODE_RUN;
                else if (i_key == bacl_pkg::KEY_SET_TIME) n_mode = bacl_pkg::MODE_SET_TIME;
                else if (i_key == bacl_pkg::KEY_SET_ALARM) n_mode = bacl_pkg::MODE_SET_ALARM;
                else n_mode = r_mode;
            end
            bacl_pkg::MODE_SET_TIME, bacl_pkg::MODE_SET_ALARM: begin
                if (w_leave && w_edit_ok) begin
                    n_mode = (i_key == bacl_pkg::KEY_RUN) ? bacl_pkg::MODE_RUN
                                                          : bacl_pkg::MODE_STOPPED;
                end
            end
            default: n_mode = r_mode;
        endcase
    end

    // outputs and digit updates
    always_comb begin
        n_time  = r_time;
        n_alarm = r_alarm;
        w_alarm = 1'b0;
        w_err   = 1'b0;
        unique case (r_mode)
            bacl_pkg::MODE_RUN: begin
                if (i_key == bacl_pkg::KEY_TICK) begin
                    w_alarm = (r_time[3:0] == r_alarm[3:0]);
                    n_time  = w_ticked;
                end else if (i_key != bacl_pkg::KEY_STOP) begin
                    w_err = 1'b1;
                end
            end
            bacl_pkg::MODE_STOPPED: begin
                if (i_key == bacl_pkg::KEY_CLEAR) begin
                    n_time = '0;
                end else begin
                    w_err = (i_key != bacl_pkg::KEY_RUN) && (i_key != bacl_pkg::KEY_SET_TIME) &&
                            (i_key != bacl_pkg::KEY_SET_ALARM) && (i_key != bacl_pkg::KEY_TICK);
                end
            end
            bacl_pkg::MODE_SET_TIME, bacl_pkg::MODE_SET_ALARM: begin
                priority if (w_leave) begin
                    w_err = !w_edit_ok;
                end else if (w_digit) begin
                    if (r_mode == bacl_pkg::MODE_SET_ALARM) n_alarm = w_shifted;
                    else n_time = w_shifted;
                end else begin
                    w_err = (i_key != bacl_pkg::KEY_TICK);
                end
            end
            default: w_err = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= bacl_pkg::MODE_RUN;
            r_time  <= '0;
            r_alarm <= '0;
        end else if (i_en) begin
            r_mode  <= n_mode;
            r_time  <= n_time;
            r_alarm <= n_alarm;
        end
    end

    assign o_res.hour_tens   = n_time[0][1:0];
    assign o_res.hour_ones   = n_time[1];
    assign o_res.minute_tens = n_time[2];
    assign o_res.minute_ones = n_time[3];
    assign o_res.second_tens = n_time[4];
    assign o_res.second_ones = n_time[5];
    assign o_res.mode        = n_mode;
    assign o_res.alarm_beep  = w_alarm;
    assign o_res.error_beep  = w_err;

endmodule

// ----- design/bcd_alarm_clock_keypad_control_top.sv -----
// A key request is registered at the input; the result register loads when the
// core state updates, which waits while a held result has not been taken.
// The block takes one key request per cycle while the result channel is not stalled.
// Reset (synchronous, active low): time and alarm digits zero, run mode,
// both pipeline registers empty.
// ----------------------------------------------------------------------------
// bcd_alarm_clock_keypad_control_top
// 24-hour BCD clock with alarm driven by keypad codes and tick requests.
// ----------------------------------------------------------------------------
module bcd_alarm_clock_keypad_control_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bacl_key_if.sink   i_key,
    bacl_res_if.source o_res
);

    logic              r_in_valid;
    logic [4:0]        r_key;
    logic              r_out_valid;
    bacl_pkg::t_result r_res;
    bacl_pkg::t_result w_res;
    logic              w_adv;

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_key.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_key.ready) begin
            r_in_valid <= i_key.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key.ready && i_key.valid) begin
            r_key <= i_key.key_code;
        end
    end

    bacl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_key   (r_key),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.hour_tens   = r_res.hour_tens;
    assign o_res.hour_ones   = r_res.hour_ones;
    assign o_res.minute_tens = r_res.minute_tens;
    assign o_res.minute_ones = r_res.minute_ones;
    assign o_res.second_tens = r_res.second_tens;
    assign o_res.second_ones = r_res.second_ones;
    assign o_res.mode        = r_res.mode;
    assign o_res.alarm_beep  = r_res.alarm_beep;
    assign o_res.error_beep  = r_res.error_beep;

    a_beep_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.alarm_beep && o_res.error_beep))
        else $error("alarm and error beep together");

    a_alarm_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.alarm_beep) |-> (o_res.mode == bacl_pkg::MODE_RUN))
        else $error("alarm beep outside run mode");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_key.ready && !o_res.valid))
        else $error("pipeline not empty after reset");

endmodule

// ----- tb/sv/bcd_alarm_clock_keypad_control_top_tb.sv -----
// ----------------------------------------------------------------------------
// bcd_alarm_clock_keypad_control_top_tb
// Drives keypad and tick requests through the key channel with random gaps.
// A behavioral clock model predicts every display result, and each result is
// compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
module bcd_alarm_clock_keypad_control_top_tb;
    import bacl_pkg::*;

    localparam int TOTAL_KEYS  = 950;
    localparam int QUIET_KEYS  = 120;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 10;
    localparam int MAX_PRINTS  = 20;

    typedef logic [KEY_W-1:0] t_key;

    localparam t_key KEY_UNUSED = 5'd15;

    typedef struct packed {
        t_digits time_d;
        t_digits alarm_d;
        t_mode   mode;
    } t_clock;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bacl_key_if key_ch ();
    bacl_res_if res_ch ();

    bcd_alarm_clock_keypad_control_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_ch),
        .o_res   (res_ch)
    );

    t_key    pending[$];
    t_result expected[$];
    t_clock  gen_clock;
    t_clock  model_clock;

    int total_keys   = 0;
    int keys_done    = 0;
    int results_done = 0;
    int error_count  = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int idle_cycles  = 0;
    int ticks_seen   = 0;
    int alarm_count  = 0;
    int reject_count = 0;

    always #6 i_clk = ~i_clk;

    function automatic logic entry_ok(t_digits d);
        int hours;
        hours = int'(d[0]) * 10 + int'(d[1]);
        return d[4] <= LAST_TENS && d[2] <= LAST_TENS && hours < int'(HOURS_PER_DAY);
    endfunction

    function automatic t_digits tick_digits(t_digits d);
        if (d[5] != LAST_ONES) begin
            d[5] = d[5] + 4'd1;
            return d;
        end
        d[5] = '0;
        if (d[4] != LAST_TENS) begin
            d[4] = d[4] + 4'd1;
            return d;
        end
        d[4] = '0;
        if (d[3] != LAST_ONES) begin
            d[3] = d[3] + 4'd1;
            return d;
        end
        d[3] = '0;
        if (d[2] != LAST_TENS) begin
            d[2] = d[2] + 4'd1;
            return d;
        end
        d[2] = '0;
        if (d[1] == LAST_ONES && d[0] <= 4'd1) begin
            d[1] = '0;
            d[0] = d[0] + 4'd1;
        end else if (d[1] == 4'd3 && d[0] == 4'd2) begin
            d[1] = '0;
            d[0] = '0;
        end else begin
            d[1] = d[1] + 4'd1;
        end
        return d;
    endfunction

    function automatic t_result advance_clock(inout t_clock st, input t_key key);
        t_result r;
        t_digits entry;
        logic    alarm_hit;
        logic    bad_key;
        logic    edit_time;
        alarm_hit = 1'b0;
        bad_key   = 1'b0;
        case (st.mode)
            MODE_RUN: begin
                if (key == KEY_TICK) begin
                    alarm_hit = st.time_d[3:0] == st.alarm_d[3:0];
                    st.time_d = tick_digits(st.time_d);
                end else if (key == KEY_STOP) begin
                    st.mode = MODE_STOPPED;
                end else begin
                    bad_key = 1'b1;
                end
            end
            MODE_STOPPED: begin
                if (key == KEY_RUN) st.mode = MODE_RUN;
                else if (key == KEY_SET_TIME) st.mode = MODE_SET_TIME;
                else if (key == KEY_CLEAR) st.time_d = '0;
                else if (key == KEY_SET_ALARM) st.mode = MODE_SET_ALARM;
                else if (key != KEY_TICK) bad_key = 1'b1;
            end
            default: begin
                edit_time = st.mode == MODE_SET_TIME;
                entry = edit_time ? st.time_d : st.alarm_d;
                if (key == KEY_RUN || key == KEY_STOP) begin
                    if (!entry_ok(entry)) bad_key = 1'b1;
                    else st.mode = (key == KEY_RUN) ? MODE_RUN : MODE_STOPPED;
                end else if (key < KEY_RUN) begin
                    // new digit enters at second ones, the rest move toward hour tens
                    entry = {key[3:0], entry[5:1]};
                end else if (key != KEY_TICK) begin
                    bad_key = 1'b1;
                end
                if (edit_time) st.time_d = entry;
                else st.alarm_d = entry;
            end
        endcase
        r.hour_tens   = st.time_d[0][1:0];
        r.hour_ones   = st.time_d[1];
        r.minute_tens = st.time_d[2];
        r.minute_ones = st.time_d[3];
        r.second_tens = st.time_d[4];
        r.second_ones = st.time_d[5];
        r.mode        = st.mode;
        r.alarm_beep  = alarm_hit;
        r.error_beep  = bad_key;
        return r;
    endfunction

    function automatic logic steady_stretch(int left);
        return left < QUIET_KEYS || (left / 80) % 3 == 0;
    endfunction

    task automatic push_key(t_key key);
        pending.push_back(key);
        void'(advance_clock(gen_clock, key));
    endtask

    task automatic push_digits(int hh, int mm, int ss);
        push_key(t_key'(hh / 10));
        push_key(t_key'(hh % 10));
        push_key(t_key'(mm / 10));
        push_key(t_key'(mm % 10));
        push_key(t_key'(ss / 10));
        push_key(t_key'(ss % 10));
    endtask

    // valid entry, biased toward rollovers; alarm often copies the current time
    task automatic push_valid_entry();
        int hh;
        int mm;
        int ss;
        if (gen_clock.mode == MODE_SET_ALARM && $urandom_range(0, 1) == 1) begin
            hh = int'(gen_clock.time_d[0]) * 10 + int'(gen_clock.time_d[1]);
            mm = int'(gen_clock.time_d[2]) * 10 + int'(gen_clock.time_d[3]);
        end else begin
            case ($urandom_range(0, 3))
                0: hh = 9;
                1: hh = 19;
                2: hh = 23;
                default: hh = $urandom_range(0, 23);
            endcase
            mm = ($urandom_range(0, 1) == 1) ? 59 : $urandom_range(0, 59);
        end
        ss = ($urandom_range(0, 1) == 1) ? $urandom_range(30, 59) : $urandom_range(0, 59);
        push_digits(hh, mm, ss);
    endtask

    task automatic push_leave_key();
        push_key(($urandom_range(0, 1) == 1) ? KEY_RUN : KEY_STOP);
    endtask

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(string name, int idx, logic [3:0] got, logic [3:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0h, expected %0h", idx, name, got, want));
    endtask

    always @(posedge i_clk) begin : key_driver
        t_key    key;
        t_result want;
        if (!i_rst_n) begin
            key_ch.valid    <= 1'b0;
            key_ch.key_code <= '0;
            send_gap = 0;
        end else begin
            if (key_ch.valid && key_ch.ready) begin
                key = key_ch.key_code;
                if (model_clock.mode == MODE_RUN && key == KEY_TICK) ticks_seen++;
                want = advance_clock(model_clock, key);
                alarm_count  += want.alarm_beep;
                reject_count += want.error_beep;
                expected.push_back(want);
                keys_done++;
            end
            if (!key_ch.valid || key_ch.ready) begin
                if (send_gap > 0) begin
                    key_ch.valid <= 1'b0;
                    send_gap--;
                end else if (pending.size() == 0) begin
                    key_ch.valid <= 1'b0;
                end else if (!steady_stretch(pending.size()) && $urandom_range(0, 7) == 0) begin
                    key_ch.valid <= 1'b0;
                    send_gap = $urandom_range(0, 15);
                end else begin
                    key_ch.valid    <= 1'b1;
                    key_ch.key_code <= pending.pop_front();
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.hour_tens   = res_ch.hour_tens;
                got.hour_ones   = res_ch.hour_ones;
                got.minute_tens = res_ch.minute_tens;
                got.minute_ones = res_ch.minute_ones;
                got.second_tens = res_ch.second_tens;
                got.second_ones = res_ch.second_ones;
                got.mode        = t_mode'(res_ch.mode);
                got.alarm_beep  = res_ch.alarm_beep;
                got.error_beep  = res_ch.error_beep;
                if (expected.size() == 0) begin
                    report_error($sformatf("result %0d with no request pending", results_done));
                end else begin
                    want = expected.pop_front();
                    compare_field("hour_tens", results_done, got.hour_tens, want.hour_tens);
                    compare_field("hour_ones", results_done, got.hour_ones, want.hour_ones);
                    compare_field("minute_tens", results_done, got.minute_tens,
                                  want.minute_tens);
                    compare_field("minute_ones", results_done, got.minute_ones,
                                  want.minute_ones);
                    compare_field("second_tens", results_done, got.second_tens,
                                  want.second_tens);
                    compare_field("second_ones", results_done, got.second_ones,
                                  want.second_ones);
                    compare_field("mode", results_done, got.mode, want.mode);
                    compare_field("alarm_beep", results_done, got.alarm_beep, want.alarm_beep);
                    compare_field("error_beep", results_done, got.error_beep, want.error_beep);
                end
                results_done++;
            end
            if (recv_gap > 0) begin
                res_ch.ready <= 1'b0;
                recv_gap--;
            end else if (!steady_stretch(total_keys - results_done)
                         && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                recv_gap = $urandom_range(0, 15);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int pick;
        gen_clock       = '0;
        model_clock     = '0;

        // run-mode tick with matching alarm, bad keys in run and stopped modes
        push_key(KEY_TICK);
        push_key(t_key'(0));
        push_key(KEY_UNUSED);
        push_key(KEY_STOP);
        push_key(KEY_TICK);
        push_key(t_key'(9));
        push_key(KEY_CLEAR);
        // last second of the day, then midnight wrap
        push_key(KEY_SET_TIME);
        push_digits(23, 59, 59);
        push_key(KEY_TICK);
        push_key(KEY_RUN);
        push_key(KEY_TICK);
        // bad entry refused on leave, bad key while setting
        push_key(KEY_STOP);
        push_key(KEY_SET_TIME);
        repeat (3) push_key(t_key'(9));
        push_key(KEY_RUN);
        push_key(KEY_SET_ALARM);

        while (pending.size() < TOTAL_KEYS) begin
            pick = $urandom_range(0, 9);
            case (gen_clock.mode)
                MODE_RUN: begin
                    if (pick < 6) repeat ($urandom_range(1, 30)) push_key(KEY_TICK);
                    else if (pick < 9) push_key(KEY_STOP);
                    else push_key(t_key'($urandom_range(0, 16)));
                end
                MODE_STOPPED: begin
                    if (pick < 3) push_key(KEY_SET_TIME);
                    else if (pick < 5) push_key(KEY_SET_ALARM);
                    else if (pick < 7) push_key(KEY_RUN);
                    else if (pick == 7) push_key(KEY_CLEAR);
                    else if (pick == 8) push_key(KEY_TICK);
                    else push_key(t_key'($urandom_range(0, 16)));
                end
                default: begin
                    if (pick < 6) begin
                        push_valid_entry();
                        push_leave_key();
                    end else if (pick < 8) begin
                        repeat ($urandom_range(1, 8)) push_key(t_key'($urandom_range(0, 9)));
                        push_leave_key();
                    end else if (pick == 8) begin
                        push_key(t_key'($urandom_range(KEY_SET_TIME, KEY_TICK)));
                    end else begin
                        push_leave_key();
                    end
                end
            endcase
        end
        total_keys = pending.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (keys_done < total_keys || expected.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d key requests: %0d clock ticks, %0d alarm beeps,",
                 total_keys, ticks_seen, alarm_count);
        $display("%0d rejected keys or entries, %0d mismatches.", reject_count, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/bacl_pkg.sv
design/bacl_if.sv
design/bacl_tick.sv
design/bacl_core.sv
design/bcd_alarm_clock_keypad_control_top.sv
tb/sv/bcd_alarm_clock_keypad_control_top_tb.sv
